// ----- rtl/core/vdi_pkg.sv -----
// shared constants, types and command/status bundles for the vertex dedup indexer
package vdi_pkg;

    localparam int VERTEX_CAPACITY = 4096;
    localparam int SLOT_COUNT      = 8192;

    localparam int SLOT_AW  = $clog2(SLOT_COUNT);
    localparam int KEY_AW   = $clog2(VERTEX_CAPACITY);
    localparam int ENTRY_W  = $clog2(VERTEX_CAPACITY + 1);
    localparam int IDX_W    = 12;
    localparam int WORD_W   = 32;
    localparam int KEY_W    = 8 * WORD_W;
    localparam int S_DATA_W = 272;
    localparam int M_DATA_W = 16;

    localparam logic [WORD_W-1:0] HASH_MUL_A = 32'd5209;
    localparam logic [WORD_W-1:0] HASH_MUL_B = 32'd1811;
    localparam logic [WORD_W-1:0] HASH_MUL_C = 32'd7297;

    typedef enum logic [2:0] {
        RES_HOLD = 3'd0,
        RES_PASS = 3'd1,
        RES_NEW  = 3'd2,
        RES_HIT  = 3'd3,
        RES_OVF  = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     clear_init;
        logic     clear_step;
        logic     probe_init;
        logic     probe_next;
        logic     insert;
        res_sel_t res_sel;
        logic     out_load;
    } vdi_cmd_t;

    typedef struct packed {
        logic start_mesh;
        logic dedup;
        logic clear_last;
        logic slot_empty;
        logic table_full;
        logic key_match;
        logic probe_last;
        logic out_free;
    } vdi_status_t;

endpackage

// ----- rtl/core/vdi_datapath.sv -----
// datapath: input capture, hash, slot and key memories, result register
module vdi_datapath
    import vdi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  vdi_cmd_t            cmd,
    output vdi_status_t         status,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready
);

    logic                dedup_reg;
    logic                start_reg;
    logic [IDX_W-1:0]    src_idx_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [WORD_W-1:0]   prod_reg [8];
    logic [WORD_W-1:0]   hp, ht, hn, hash_full;
    logic [SLOT_AW-1:0]  probe_addr_reg;
    logic [SLOT_AW-1:0]  probe_cnt_reg;
    logic [SLOT_AW-1:0]  clr_addr_reg;
    logic [ENTRY_W-1:0]  count_reg;
    logic [ENTRY_W-1:0]  slot_rd_reg;
    logic [KEY_W-1:0]    key_rd_reg;
    logic [ENTRY_W-1:0]  hit_idx;
    logic [IDX_W-1:0]    res_idx_reg;
    logic                res_new_reg;
    logic                res_ovf_reg;
    logic                m_valid_reg;
    logic [ENTRY_W-1:0]  slot_mem [SLOT_COUNT];
    logic [KEY_W-1:0]    key_mem  [VERTEX_CAPACITY];
    logic                slot_we;
    logic [SLOT_AW-1:0]  slot_waddr;
    logic [ENTRY_W-1:0]  slot_wdata;

    // hash from registered products
    assign hp = prod_reg[0] ^ prod_reg[1] ^ prod_reg[2];
    assign ht = prod_reg[3] ^ prod_reg[4];
    assign hn = prod_reg[5] ^ prod_reg[6] ^ prod_reg[7];
    assign hash_full = ((hp ^ (ht << 1)) >> 1) ^ (hn << 1);

    assign hit_idx = slot_rd_reg - ENTRY_W'(1);

    always_ff @(posedge aclk) begin
        prod_reg[0] <= key_reg[0*WORD_W +: WORD_W] * HASH_MUL_A;
        prod_reg[1] <= key_reg[1*WORD_W +: WORD_W] * HASH_MUL_B;
        prod_reg[2] <= key_reg[2*WORD_W +: WORD_W] * HASH_MUL_C;
        prod_reg[3] <= key_reg[3*WORD_W +: WORD_W] * HASH_MUL_A;
        prod_reg[4] <= key_reg[4*WORD_W +: WORD_W] * HASH_MUL_B;
        prod_reg[5] <= key_reg[5*WORD_W +: WORD_W] * HASH_MUL_A;
        prod_reg[6] <= key_reg[6*WORD_W +: WORD_W] * HASH_MUL_B;
        prod_reg[7] <= key_reg[7*WORD_W +: WORD_W] * HASH_MUL_C;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            start_reg   <= s_tuser;
            src_idx_reg <= s_tdata[IDX_W-1:0];
            key_reg     <= s_tdata[IDX_W +: KEY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dedup_reg <= 1'b1;
        end else if (cfg_valid) begin
            dedup_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end else begin
            if (cmd.clear_init) begin
                clr_addr_reg <= '0;
                count_reg    <= '0;
            end else begin
                if (cmd.clear_step) begin
                    clr_addr_reg <= clr_addr_reg + SLOT_AW'(1);
                end
                if (cmd.insert) begin
                    count_reg <= count_reg + ENTRY_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.probe_init) begin
            probe_addr_reg <= hash_full[SLOT_AW-1:0];
            probe_cnt_reg  <= '0;
        end else if (cmd.probe_next) begin
            probe_addr_reg <= probe_addr_reg + SLOT_AW'(1);
            probe_cnt_reg  <= probe_cnt_reg + SLOT_AW'(1);
        end
    end

    // one write port shared by the clear sweep and insertion
    always_comb begin
        slot_we    = cmd.clear_step | cmd.insert;
        slot_waddr = cmd.clear_step ? clr_addr_reg : probe_addr_reg;
        slot_wdata = cmd.clear_step ? '0 : count_reg + ENTRY_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[probe_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            key_mem[count_reg[KEY_AW-1:0]] <= key_reg;
        end
        key_rd_reg <= key_mem[hit_idx[KEY_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.res_sel)
            RES_PASS: begin
                res_idx_reg <= src_idx_reg;
                res_new_reg <= 1'b0;
                res_ovf_reg <= 1'b0;
            end
            RES_NEW: begin
                res_idx_reg <= count_reg[IDX_W-1:0];
                res_new_reg <= 1'b1;
                res_ovf_reg <= 1'b0;
            end
            RES_HIT: begin
                res_idx_reg <= hit_idx[IDX_W-1:0];
                res_new_reg <= 1'b0;
                res_ovf_reg <= 1'b0;
            end
            RES_OVF: begin
                res_idx_reg <= '0;
                res_new_reg <= 1'b0;
                res_ovf_reg <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register
    logic [IDX_W-1:0] out_idx_reg;
    logic [1:0]       out_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_idx_reg   <= res_idx_reg;
            out_flags_reg <= {res_ovf_reg, res_new_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W){1'b0}}, out_idx_reg};
    assign m_tuser  = out_flags_reg;

    always_comb begin
        status.start_mesh = start_reg;
        status.dedup      = dedup_reg;
        status.clear_last = (clr_addr_reg == SLOT_AW'(SLOT_COUNT - 1));
        status.slot_empty = (slot_rd_reg == '0);
        status.table_full = (count_reg >= ENTRY_W'(VERTEX_CAPACITY));
        status.key_match  = (key_rd_reg == key_reg);
        status.probe_last = (probe_cnt_reg == SLOT_AW'(SLOT_COUNT - 1));
        status.out_free   = !m_valid_reg || m_tready;
    end

endmodule

// ----- rtl/core/vdi_ctrl.sv -----
// controller state machine: clear sweep, hashing, linear probe, result hand-off
module vdi_ctrl
    import vdi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  vdi_status_t status,
    output vdi_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_HASH1 = 8'b0000_0100,
        ST_HASH2 = 8'b0000_1000,
        ST_SLOT  = 8'b0001_0000,
        ST_CHK   = 8'b0010_0000,
        ST_CMP   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        cmd.res_sel  = RES_HOLD;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    if (!pending_reg) begin
                        state_next = ST_IDLE;
                    end else if (status.dedup) begin
                        state_next = ST_HASH1;
                    end else begin
                        cmd.res_sel = RES_PASS;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_HASH1;
                end
            end
            ST_HASH1: begin
                // input registers are loaded now
                if (status.start_mesh && !pending_reg) begin
                    cmd.clear_init = 1'b1;
                    pending_next   = 1'b1;
                    state_next     = ST_CLEAR;
                end else if (!status.dedup) begin
                    cmd.res_sel = RES_PASS;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_HASH2;
                end
            end
            ST_HASH2: begin
                cmd.probe_init = 1'b1;
                state_next     = ST_SLOT;
            end
            ST_SLOT: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (status.slot_empty) begin
                    if (status.table_full) begin
                        cmd.res_sel = RES_OVF;
                    end else begin
                        cmd.insert  = 1'b1;
                        cmd.res_sel = RES_NEW;
                    end
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.key_match) begin
                    cmd.res_sel = RES_HIT;
                    state_next  = ST_DONE;
                end else if (status.probe_last) begin
                    cmd.res_sel = RES_OVF;
                    state_next  = ST_DONE;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_SLOT;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    pending_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/vertex_dedup_indexer_top.sv -----
// top level of the vertex dedup indexer: controller plus datapath
//
// channel   dir  handshake                  payload
// s_        in   s_tvalid / s_tready        s_tdata (index, key words), s_tuser (start_mesh)
// m_        out  m_tvalid / m_tready        m_tdata (vertex_index), m_tuser (is_new, overflow)
// cfg_      in   cfg_valid / cfg_ready      cfg_data (dedup_enable)
//
// one transaction in gives one transaction out; with dedup off the source index passes through,
// with dedup on the key is hashed and the slot memory is probed linearly until an empty slot or a key match
// each probe step reads the slot memory and then the key memory
// reset and every mesh start run a clearing pass over all 8192 slots of the slot memory
// the result register lets the next transaction in while a result waits for m_tready
module vertex_dedup_indexer_top
    import vdi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // source_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                                           // norm_x, norm_y, norm_z, zero pad
    input  logic                s_tuser,   // start_mesh
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // vertex_index, zero pad
    output logic [1:0]          m_tuser,   // is_new, overflow
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data   // dedup_enable
);

    vdi_cmd_t    cmd;
    vdi_status_t status;

    // register writes are to come only while idle, which the block does not enforce; they are always taken
    assign cfg_ready = 1'b1;

    vdi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vdi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule
